### rtl/core/acdfa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Aho-Corasick DFA scan block.
// Used by acdfa_front, acdfa_queue, acdfa_back and aho_corasick_dfa_scan.
package acdfa_pkg;

   // Default table sizes
   localparam int DEF_MAX_STATES    = 1024;
   localparam int DEF_MATCH_ENTRIES = 4096;
   localparam int DEF_MAX_MATCHES   = 16;
   localparam int DEF_ALPHABET      = 256;

   // Depth of the request queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Fixed-point shift for the reciprocal used in the match index wrap
   localparam int RECIP_SHIFT = 24;

   // Field widths
   localparam int STATE_W = 10;
   localparam int SYM_W   = 8;
   localparam int DEPTH_W = 8;
   localparam int START_W = 12;
   localparam int MCNT_W  = 5;
   localparam int PAT_W   = 10;
   localparam int DIST_W  = 9;
   localparam int RANK_W  = 6;

   typedef enum logic [1:0] {
      OP_WR_TRANS = 2'd0,
      OP_WR_INFO  = 2'd1,
      OP_WR_MATCH = 2'd2,
      OP_SCAN     = 2'd3
   } op_type;

   // Request as it sits in the queue
   typedef struct packed {
      op_type              op;
      logic                lookup_ok;
      logic [STATE_W-1:0]  state_index;
      logic [SYM_W-1:0]    byte_value;
      logic [STATE_W-1:0]  target_state;
      logic [DEPTH_W-1:0]  depth_value;
      logic [START_W-1:0]  match_start;
      logic [MCNT_W-1:0]   match_count;
      logic [PAT_W-1:0]    pattern_id;
      logic                check_depth;
      logic [DIST_W-1:0]   distance;
      logic [RANK_W-1:0]   rank;
   } cmd_type;

   // One state-info entry
   typedef struct packed {
      logic [DEPTH_W-1:0]  depth;
      logic [START_W-1:0]  start;
      logic [MCNT_W-1:0]   count;
   } info_type;

   // One result
   typedef struct packed {
      logic [STATE_W-1:0]  next_state;
      logic                rejected;
      logic                hit;
      logic [PAT_W-1:0]    match_pattern;
      logic [RANK_W-1:0]   result_rank;
      logic                last;
   } rsp_type;

   // Queue status seen by front, back and top
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_TRANS,
      BK_INFO,
      BK_MODQ,
      BK_MODF,
      BK_EMIT
   } back_state_type;

endpackage

### rtl/core/acdfa_queue.sv
`timescale 1ns / 1ps
// Small request queue between the front and back parts.
// Depends on acdfa_pkg for the request type.
module acdfa_queue #(
   parameter int DEPTH = acdfa_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  acdfa_pkg::cmd_type          wr_data,
   input  logic                        rd_en,
   output acdfa_pkg::cmd_type          rd_data,
   output acdfa_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   acdfa_pkg::cmd_type slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_wr, do_rd;

   // Qualify the handshake against the fill level
   always_comb begin
      status.full  = (32'(count_ff) == DEPTH);
      status.empty = (count_ff == '0);
      do_wr        = wr_en && !status.full;
      do_rd        = rd_en && !status.empty;
      rd_data      = slot_ff[rd_ptr_ff];
   end

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (32'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (32'(rd_ptr_ff) == DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold stored requests
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### rtl/core/acdfa_front.sv
`timescale 1ns / 1ps
// Front part: takes requests, range-checks them and drops table writes
// that fall outside the stores. Depends on acdfa_pkg.
module acdfa_front #(
   parameter int MAX_STATES    = acdfa_pkg::DEF_MAX_STATES,
   parameter int MATCH_ENTRIES = acdfa_pkg::DEF_MATCH_ENTRIES,
   parameter int ALPHABET      = acdfa_pkg::DEF_ALPHABET
) (
   input  logic                                push,
   output logic                                full,
   input  logic [1:0]                          req_op,
   input  logic [acdfa_pkg::STATE_W-1:0]       req_state_index,
   input  logic [acdfa_pkg::SYM_W-1:0]         req_byte_value,
   input  logic [acdfa_pkg::STATE_W-1:0]       req_target_state,
   input  logic [acdfa_pkg::DEPTH_W-1:0]       req_depth_value,
   input  logic [acdfa_pkg::START_W-1:0]       req_match_start,
   input  logic [acdfa_pkg::MCNT_W-1:0]        req_match_count,
   input  logic [acdfa_pkg::PAT_W-1:0]         req_pattern_id,
   input  logic                                req_check_depth,
   input  logic [acdfa_pkg::DIST_W-1:0]        req_distance,
   input  logic [acdfa_pkg::RANK_W-1:0]        req_rank,
   input  acdfa_pkg::queue_status_type         q_status,
   output logic                                q_push,
   output acdfa_pkg::cmd_type                  q_data
);

   acdfa_pkg::op_type op;
   logic              state_ok, sym_ok, entry_ok, keep;

   // Classify the request
   always_comb begin
      op       = acdfa_pkg::op_type'(req_op);
      state_ok = (32'(req_state_index) < MAX_STATES);
      sym_ok   = (32'(req_byte_value) < ALPHABET);
      entry_ok = (32'(req_match_start) < MATCH_ENTRIES);
      case (op)
         acdfa_pkg::OP_WR_TRANS: keep = state_ok && sym_ok;
         acdfa_pkg::OP_WR_INFO:  keep = state_ok;
         acdfa_pkg::OP_WR_MATCH: keep = entry_ok;
         acdfa_pkg::OP_SCAN:     keep = 1'b1;
         default:                keep = 1'b0;
      endcase
   end

   // Pack the request and drop out-of-range writes
   always_comb begin
      q_data.op           = op;
      q_data.lookup_ok    = state_ok && sym_ok;
      q_data.state_index  = req_state_index;
      q_data.byte_value   = req_byte_value;
      q_data.target_state = req_target_state;
      q_data.depth_value  = req_depth_value;
      q_data.match_start  = req_match_start;
      q_data.match_count  = req_match_count;
      q_data.pattern_id   = req_pattern_id;
      q_data.check_depth  = req_check_depth;
      q_data.distance     = req_distance;
      q_data.rank         = req_rank;
      full                = q_status.full;
      q_push              = push && !q_status.full && keep;
   end

endmodule

### rtl/core/acdfa_back.sv
`timescale 1ns / 1ps
// Back part: owns the three table memories, runs table writes and scans,
// and walks the match list into a one-entry result register. Depends on acdfa_pkg.
module acdfa_back #(
   parameter int MAX_STATES            = acdfa_pkg::DEF_MAX_STATES,
   parameter int MATCH_ENTRIES         = acdfa_pkg::DEF_MATCH_ENTRIES,
   parameter int MAX_MATCHES_PER_STATE = acdfa_pkg::DEF_MAX_MATCHES,
   parameter int ALPHABET              = acdfa_pkg::DEF_ALPHABET
) (
   input  logic                clock,
   input  logic                reset,
   input  acdfa_pkg::cmd_type  q_data,
   input  logic                q_empty,
   output logic                q_pop,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output acdfa_pkg::rsp_type  rsp_data
);

   localparam int TR_DEPTH = MAX_STATES * ALPHABET;
   localparam int TR_AW    = $clog2(TR_DEPTH);
   localparam int ST_AW    = $clog2(MAX_STATES);
   localparam int MA_AW    = (MATCH_ENTRIES > 1) ? $clog2(MATCH_ENTRIES) : 1;
   localparam int CNT_W    = $clog2(MAX_MATCHES_PER_STATE + 1);
   localparam int RECIP    = (1 << acdfa_pkg::RECIP_SHIFT) / MATCH_ENTRIES;
   localparam int PROD_W   = acdfa_pkg::START_W + acdfa_pkg::RECIP_SHIFT + 1;
   localparam int QUO_W    = PROD_W - acdfa_pkg::RECIP_SHIFT;

   // Table memories
   logic [acdfa_pkg::STATE_W-1:0] tr_mem [TR_DEPTH];
   acdfa_pkg::info_type           info_mem [MAX_STATES];
   logic [acdfa_pkg::PAT_W-1:0]   match_mem [MATCH_ENTRIES];

   logic [acdfa_pkg::STATE_W-1:0] tr_rd_ff;
   acdfa_pkg::info_type           info_rd_ff;
   logic [acdfa_pkg::PAT_W-1:0]   m_rd_ff;

   acdfa_pkg::back_state_type state_ff, state_in;

   // Scan context
   logic [acdfa_pkg::STATE_W-1:0] st_ff;
   logic                          chk_ff, ok_ff;
   logic [acdfa_pkg::DIST_W-1:0]  dist_ff;
   logic [acdfa_pkg::RANK_W-1:0]  rank_ff;
   logic [acdfa_pkg::STATE_W-1:0] ns_ff, ns_in;
   logic                          ns_ok_ff, ns_ok_in;
   logic [acdfa_pkg::START_W-1:0] start_ff;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [PROD_W-1:0]             prod_ff, prod_in;
   logic [acdfa_pkg::START_W-1:0] rem_ff, rem_in;
   logic [MA_AW-1:0]              idx_ff, idx_in;
   logic [CNT_W-1:0]              k_ff, k_in;

   // Result register
   logic                          out_valid_ff;
   acdfa_pkg::rsp_type            out_ff, out_in;

   // Control
   logic                          tr_we, tr_re, info_we, info_re, m_we, m_re;
   logic                          ctx_load, ns_load, cnt_load, rem_load, idx_load;
   logic                          out_load, out_free;
   logic [TR_AW-1:0]              tr_addr;
   logic [ST_AW-1:0]              info_waddr, info_raddr;
   logic [MA_AW-1:0]              m_waddr, m_raddr;
   acdfa_pkg::info_type           info_wdata, info_cur;
   logic                          reject, single, emit_last;
   logic [QUO_W-1:0]              quo;
   logic [31:0]                   quo_m;
   logic [MA_AW-1:0]              idx_fix, idx_next;

   // Datapath terms
   always_comb begin
      tr_addr    = TR_AW'(32'(q_data.state_index) * 32'(ALPHABET)
                        + 32'(q_data.byte_value));
      info_waddr = ST_AW'(q_data.state_index);
      m_waddr    = MA_AW'(q_data.match_start);
      info_wdata.depth = q_data.depth_value;
      info_wdata.start = q_data.match_start;
      info_wdata.count = q_data.match_count;

      // next state of the scan; zero when the lookup is out of range
      ns_in      = ok_ff ? tr_rd_ff : '0;
      ns_ok_in   = (32'(ns_in) < MAX_STATES);
      info_raddr = ST_AW'(ns_in);

      // state info of the next state; zero when out of range
      info_cur = ns_ok_ff ? info_rd_ff : '0;
      cnt_in   = (32'(info_cur.count) > MAX_MATCHES_PER_STATE)
                 ? CNT_W'(MAX_MATCHES_PER_STATE) : CNT_W'(info_cur.count);
      reject   = chk_ff && ({2'b00, info_cur.depth} <= ({1'b0, dist_ff} + 10'd1));
      single   = reject || (cnt_in == '0);
      prod_in  = PROD_W'(info_cur.start) * PROD_W'(RECIP);

      // start modulo the match store: reciprocal estimate, then one correction
      quo      = prod_ff[PROD_W-1:acdfa_pkg::RECIP_SHIFT];
      quo_m    = 32'(quo) * 32'(MATCH_ENTRIES);
      rem_in   = acdfa_pkg::START_W'(32'(start_ff) - quo_m);
      idx_fix  = (32'(rem_ff) >= MATCH_ENTRIES)
                 ? MA_AW'(32'(rem_ff) - 32'(MATCH_ENTRIES)) : MA_AW'(rem_ff);
      idx_next = (32'(idx_ff) + 32'd1 == 32'(MATCH_ENTRIES)) ? '0 : idx_ff + 1'b1;
      emit_last = (32'(k_ff) + 32'd1 == 32'(cnt_ff));

      out_free  = !out_valid_ff || rsp_pop;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         acdfa_pkg::BK_IDLE: begin
            if (!q_empty && q_data.op == acdfa_pkg::OP_SCAN) begin
               state_in = acdfa_pkg::BK_TRANS;
            end
         end
         acdfa_pkg::BK_TRANS: state_in = acdfa_pkg::BK_INFO;
         acdfa_pkg::BK_INFO: begin
            if (!single) begin
               state_in = acdfa_pkg::BK_MODQ;
            end else if (out_free) begin
               state_in = acdfa_pkg::BK_IDLE;
            end
         end
         acdfa_pkg::BK_MODQ: state_in = acdfa_pkg::BK_MODF;
         acdfa_pkg::BK_MODF: state_in = acdfa_pkg::BK_EMIT;
         acdfa_pkg::BK_EMIT: begin
            if (out_free && emit_last) begin
               state_in = acdfa_pkg::BK_IDLE;
            end
         end
         default: state_in = acdfa_pkg::BK_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      q_pop    = 1'b0;
      tr_we    = 1'b0;
      tr_re    = 1'b0;
      info_we  = 1'b0;
      info_re  = 1'b0;
      m_we     = 1'b0;
      m_re     = 1'b0;
      ctx_load = 1'b0;
      ns_load  = 1'b0;
      cnt_load = 1'b0;
      rem_load = 1'b0;
      idx_load = 1'b0;
      out_load = 1'b0;
      m_raddr  = idx_next;
      idx_in   = idx_next;
      k_in     = k_ff + 1'b1;
      out_in.next_state    = ns_ff;
      out_in.rejected      = 1'b0;
      out_in.hit           = 1'b0;
      out_in.match_pattern = '0;
      out_in.result_rank   = rank_ff;
      out_in.last          = 1'b1;
      case (state_ff)
         acdfa_pkg::BK_IDLE: begin
            q_pop    = !q_empty;
            tr_we    = q_pop && (q_data.op == acdfa_pkg::OP_WR_TRANS);
            info_we  = q_pop && (q_data.op == acdfa_pkg::OP_WR_INFO);
            m_we     = q_pop && (q_data.op == acdfa_pkg::OP_WR_MATCH);
            tr_re    = q_pop && (q_data.op == acdfa_pkg::OP_SCAN);
            ctx_load = tr_re;
         end
         acdfa_pkg::BK_TRANS: begin
            info_re = 1'b1;
            ns_load = 1'b1;
         end
         acdfa_pkg::BK_INFO: begin
            cnt_load = !single;
            out_load = single && out_free;
            out_in.next_state = reject ? st_ff : ns_ff;
            out_in.rejected   = reject;
         end
         acdfa_pkg::BK_MODQ: begin
            rem_load = 1'b1;
         end
         acdfa_pkg::BK_MODF: begin
            m_re     = 1'b1;
            m_raddr  = idx_fix;
            idx_load = 1'b1;
            idx_in   = idx_fix;
            k_in     = '0;
         end
         acdfa_pkg::BK_EMIT: begin
            out_load = out_free;
            out_in.hit           = 1'b1;
            out_in.match_pattern = m_rd_ff;
            out_in.last          = emit_last;
            m_re     = out_free && !emit_last;
            idx_load = m_re;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= acdfa_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (ctx_load) begin
         st_ff   <= q_data.state_index;
         chk_ff  <= q_data.check_depth;
         ok_ff   <= q_data.lookup_ok;
         dist_ff <= q_data.distance;
         rank_ff <= q_data.rank;
      end
      if (ns_load) begin
         ns_ff    <= ns_in;
         ns_ok_ff <= ns_ok_in;
      end
      if (cnt_load) begin
         cnt_ff   <= cnt_in;
         start_ff <= info_cur.start;
         prod_ff  <= prod_in;
      end
      if (rem_load) begin
         rem_ff <= rem_in;
      end
      if (idx_load) begin
         idx_ff <= idx_in;
         k_ff   <= k_in;
      end
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   // Transition memory
   always_ff @(posedge clock) begin
      if (tr_we) begin
         tr_mem[tr_addr] <= q_data.target_state;
      end
      if (tr_re) begin
         tr_rd_ff <= tr_mem[tr_addr];
      end
   end

   // State-info memory
   always_ff @(posedge clock) begin
      if (info_we) begin
         info_mem[info_waddr] <= info_wdata;
      end
      if (info_re) begin
         info_rd_ff <= info_mem[info_raddr];
      end
   end

   // Match store
   always_ff @(posedge clock) begin
      if (m_we) begin
         match_mem[m_waddr] <= q_data.pattern_id;
      end
      if (m_re) begin
         m_rd_ff <= match_mem[m_raddr];
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

### rtl/core/aho_corasick_dfa_scan.sv
`timescale 1ns / 1ps
// Aho-Corasick DFA scan engine, top level: request front, queue, table back end.
// Depends on acdfa_pkg, acdfa_front, acdfa_queue and acdfa_back.
//
// Requests enter through a queue-style port (push/full) into a four-entry queue,
// so the front takes one request per cycle until that queue fills. The back end
// executes one request at a time: a table write is applied as the queue pops it; a
// scan that is rejected, or whose next state has no matches, runs a transition read,
// a state-info read and a result; when the next state lists N patterns it instead
// folds the list start into the match store (reciprocal estimate, then a correction
// and the first match read), then does one match store read per result. Results leave
// through a one-entry result register (empty/pop); the back end waits while that
// register is full and not popped. The three stores need no initialization pass;
// entries read before they are written return unspecified data.
module aho_corasick_dfa_scan #(
   parameter int MAX_STATES            = acdfa_pkg::DEF_MAX_STATES,
   parameter int MATCH_ENTRIES         = acdfa_pkg::DEF_MATCH_ENTRIES,
   parameter int MAX_MATCHES_PER_STATE = acdfa_pkg::DEF_MAX_MATCHES,
   parameter int ALPHABET              = acdfa_pkg::DEF_ALPHABET
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic [1:0]                          req_op,
   input  logic [acdfa_pkg::STATE_W-1:0]       req_state_index,
   input  logic [acdfa_pkg::SYM_W-1:0]         req_byte_value,
   input  logic [acdfa_pkg::STATE_W-1:0]       req_target_state,
   input  logic [acdfa_pkg::DEPTH_W-1:0]       req_depth_value,
   input  logic [acdfa_pkg::START_W-1:0]       req_match_start,
   input  logic [acdfa_pkg::MCNT_W-1:0]        req_match_count,
   input  logic [acdfa_pkg::PAT_W-1:0]         req_pattern_id,
   input  logic                                req_check_depth,
   input  logic [acdfa_pkg::DIST_W-1:0]        req_distance,
   input  logic [acdfa_pkg::RANK_W-1:0]        req_rank,
   output logic                                empty,
   input  logic                                pop,
   output logic [acdfa_pkg::STATE_W-1:0]       rsp_next_state,
   output logic                                rsp_rejected,
   output logic                                rsp_hit,
   output logic [acdfa_pkg::PAT_W-1:0]         rsp_match_pattern,
   output logic [acdfa_pkg::RANK_W-1:0]        rsp_result_rank,
   output logic                                rsp_last
);

   acdfa_pkg::queue_status_type q_status;
   acdfa_pkg::cmd_type          q_wr_data, q_rd_data;
   acdfa_pkg::rsp_type          rsp_data;
   logic                        q_push, q_pop;

   // Classify incoming requests
   acdfa_front #(
      .MAX_STATES    (MAX_STATES),
      .MATCH_ENTRIES (MATCH_ENTRIES),
      .ALPHABET      (ALPHABET)
   ) u_front (
      .push             (push),
      .full             (full),
      .req_op           (req_op),
      .req_state_index  (req_state_index),
      .req_byte_value   (req_byte_value),
      .req_target_state (req_target_state),
      .req_depth_value  (req_depth_value),
      .req_match_start  (req_match_start),
      .req_match_count  (req_match_count),
      .req_pattern_id   (req_pattern_id),
      .req_check_depth  (req_check_depth),
      .req_distance     (req_distance),
      .req_rank         (req_rank),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_data           (q_wr_data)
   );

   // Buffer requests between front and back
   acdfa_queue #(
      .DEPTH (acdfa_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_wr_data),
      .rd_en   (q_pop),
      .rd_data (q_rd_data),
      .status  (q_status)
   );

   // Execute writes and scans
   acdfa_back #(
      .MAX_STATES            (MAX_STATES),
      .MATCH_ENTRIES         (MATCH_ENTRIES),
      .MAX_MATCHES_PER_STATE (MAX_MATCHES_PER_STATE),
      .ALPHABET              (ALPHABET)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_data    (q_rd_data),
      .q_empty   (q_status.empty),
      .q_pop     (q_pop),
      .rsp_pop   (pop),
      .rsp_empty (empty),
      .rsp_data  (rsp_data)
   );

   assign rsp_next_state    = rsp_data.next_state;
   assign rsp_rejected      = rsp_data.rejected;
   assign rsp_hit           = rsp_data.hit;
   assign rsp_match_pattern = rsp_data.match_pattern;
   assign rsp_result_rank   = rsp_data.result_rank;
   assign rsp_last          = rsp_data.last;

   // An accepted scan request lands in the queue
   a_scan_queued: assert property (@(posedge clock) disable iff (reset)
      (push && !full && req_op == acdfa_pkg::OP_SCAN) |=> !q_status.empty)
      else $error("accepted scan request missing from queue");

   // A rejected scan gives exactly one result without a hit
   a_reject_single: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_rejected) |-> (!rsp_hit && rsp_last))
      else $error("rejected result is not a single no-hit result");

   // A no-hit result closes its scan and carries no pattern
   a_nohit_shape: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_hit) |-> (rsp_last && rsp_match_pattern == '0))
      else $error("no-hit result malformed");

endmodule
